[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/pps_pkg.sv]
package pps_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int TICK_W = 13;
    localparam int PID_W = 4;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    typedef struct packed {
        logic [7:0] arrival_time;
        logic [7:0] burst_time;
        logic [7:0] prio_level;
        logic       last_process;
    } proc_req_t;

    typedef struct packed {
        logic [PID_W-1:0]  process_id;
        logic [TICK_W-1:0] completion_time;
        logic [TICK_W-1:0] waiting_time;
        logic [TICK_W-1:0] turnaround_time;
        logic              last_result;
    } proc_res_t;

    typedef struct packed {
        logic             found;
        logic [7:0]       prio;
        logic [IDX_W-1:0] idx;
    } cand_t;

    typedef struct packed {
        logic [7:0]        arrival;
        logic [7:0]        burst;
        logic [TICK_W-1:0] finish;
        logic              final_tick;
    } cell_res_t;

endpackage

[rtl/preemptive_priority_schedule_top.sv]
// Requests load while idle and start is high; requests beyond the capacity are dropped.
// Each schedule tick lets the pick ripple through the cell chain and then applies it.
// After the last request, results follow on consecutive cycles, one per process,
// and busy falls as the last result appears, so a new set may load at once.
// Reset is asynchronous, active low, and empties the process set.
module preemptive_priority_schedule_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pps_pkg::proc_req_t req,
    output pps_pkg::proc_res_t res,
    output logic               res_strobe
);
    import pps_pkg::*;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]  loaded_reg, loaded_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [IDX_W-1:0]  emit_idx_reg, emit_idx_next;
    proc_res_t         res_reg, res_next;
    logic              res_strobe_reg, res_strobe_next;

    cand_t     cand [MAX_PROCS+1];
    cell_res_t cres [MAX_PROCS];
    logic [MAX_PROCS-1:0] load_vec;
    logic [MAX_PROCS-1:0] pick_vec;
    logic      clear;
    logic      accept;
    cell_res_t sel;
    logic [TICK_W-1:0] tat;

    assign accept = start && (state_reg == ST_LOAD);
    assign cand[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PROCS; gi++)
        begin : g_cell
            assign load_vec[gi] = accept && (loaded_reg == CNT_W'(gi));
            assign pick_vec[gi] = (state_reg == ST_APPLY) && cand[MAX_PROCS].found
                                  && (cand[MAX_PROCS].idx == IDX_W'(gi));
            pps_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (IDX_W'(gi)),
                .load_en  (load_vec[gi]),
                .load_data(req),
                .clear    (clear),
                .pick_en  (pick_vec[gi]),
                .tick     (tick_reg),
                .cand_in  (cand[gi]),
                .cand_out (cand[gi+1]),
                .cell_res (cres[gi])
            );
        end
    endgenerate

    assign sel = cres[emit_idx_reg];
    assign tat = sel.finish - {{(TICK_W-8){1'b0}}, sel.arrival};

    always_comb
    begin
        state_next = state_reg;
        scan_cnt_next = scan_cnt_reg;
        loaded_next = loaded_reg;
        left_next = left_reg;
        tick_next = tick_reg;
        emit_idx_next = emit_idx_reg;
        res_next = res_reg;
        res_strobe_next = 1'b0;
        clear = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (start)
                begin
                    if (loaded_reg < CNT_W'(MAX_PROCS))
                    begin
                        loaded_next = loaded_reg + CNT_W'(1);
                    end
                    if (req.last_process)
                    begin
                        left_next = loaded_next;
                        scan_cnt_next = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (scan_cnt_reg == CNT_W'(MAX_PROCS - 1))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                tick_next = tick_reg + TICK_W'(1);
                scan_cnt_next = '0;
                state_next = ST_SCAN;
                if (cand[MAX_PROCS].found && cres[cand[MAX_PROCS].idx].final_tick)
                begin
                    left_next = left_reg - CNT_W'(1);
                    if (left_reg == CNT_W'(1))
                    begin
                        emit_idx_next = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                res_strobe_next = 1'b1;
                res_next.process_id = PID_W'(emit_idx_reg);
                res_next.completion_time = sel.finish;
                res_next.turnaround_time = tat;
                res_next.waiting_time = tat - {{(TICK_W-8){1'b0}}, sel.burst};
                res_next.last_result = (CNT_W'(emit_idx_reg) + CNT_W'(1) == loaded_reg);
                emit_idx_next = emit_idx_reg + IDX_W'(1);
                if (res_next.last_result)
                begin
                    clear = 1'b1;
                    loaded_next = '0;
                    tick_next = '0;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            scan_cnt_reg <= '0;
            loaded_reg <= '0;
            left_reg <= '0;
            tick_reg <= '0;
            emit_idx_reg <= '0;
            res_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            loaded_reg <= loaded_next;
            left_reg <= left_next;
            tick_reg <= tick_next;
            emit_idx_reg <= emit_idx_next;
            res_strobe_reg <= res_strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy = (state_reg != ST_LOAD);
    assign res = res_reg;
    assign res_strobe = res_strobe_reg;

endmodule

[rtl/pps_cell.sv]
module pps_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [pps_pkg::IDX_W-1:0] cell_idx,
    input  logic                      load_en,
    input  pps_pkg::proc_req_t        load_data,
    input  logic                      clear,
    input  logic                      pick_en,
    input  logic [pps_pkg::TICK_W-1:0] tick,
    input  pps_pkg::cand_t            cand_in,
    output pps_pkg::cand_t            cand_out,
    output pps_pkg::cell_res_t        cell_res
);
    import pps_pkg::*;

    logic              valid_reg;
    logic              done_reg;
    logic [7:0]        arrival_reg;
    logic [7:0]        burst_reg;
    logic [7:0]        remaining_reg;
    logic [7:0]        prio_reg;
    logic [TICK_W-1:0] finish_reg;
    cand_t             cand_reg;
    cand_t             cand_next;
    logic              eligible;
    logic [7:0]        burst_fixed;

    assign burst_fixed = (load_data.burst_time == 8'd0) ? 8'd1 : load_data.burst_time;
    assign eligible = valid_reg && !done_reg && ({{(TICK_W-8){1'b0}}, arrival_reg} <= tick);

    always_comb
    begin
        cand_next = cand_in;
        if (eligible && (!cand_in.found || prio_reg > cand_in.prio))
        begin
            cand_next.found = 1'b1;
            cand_next.prio = prio_reg;
            cand_next.idx = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg <= 1'b0;
            cand_reg <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
            if (clear)
            begin
                valid_reg <= 1'b0;
                done_reg <= 1'b0;
            end
            else if (load_en)
            begin
                valid_reg <= 1'b1;
                done_reg <= 1'b0;
            end
            else if (pick_en && remaining_reg == 8'd1)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            arrival_reg <= load_data.arrival_time;
            burst_reg <= burst_fixed;
            remaining_reg <= burst_fixed;
            prio_reg <= load_data.prio_level;
        end
        else if (pick_en)
        begin
            remaining_reg <= remaining_reg - 8'd1;
            if (remaining_reg == 8'd1)
            begin
                finish_reg <= tick + TICK_W'(1);
            end
        end
    end

    assign cand_out = cand_reg;
    assign cell_res.arrival = arrival_reg;
    assign cell_res.burst = burst_reg;
    assign cell_res.finish = finish_reg;
    assign cell_res.final_tick = (remaining_reg == 8'd1);

endmodule

[rtl/pps_checker.sv]
`include "assert_macros.svh"

module pps_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input pps_pkg::proc_req_t req,
    input pps_pkg::proc_res_t res,
    input logic               res_strobe
);
    import pps_pkg::*;

    `ASSERT_SAME(a_last_frees, clk, rst_n, res_strobe && res.last_result, !busy)
    `ASSERT_NEXT(a_load_open, clk, rst_n, start && !busy && !req.last_process, !busy)
    `ASSERT_NEXT(a_last_starts, clk, rst_n, start && !busy && req.last_process, busy)
    `ASSERT_NEXT(a_results_run, clk, rst_n, res_strobe && !res.last_result, res_strobe)

endmodule

bind preemptive_priority_schedule_top pps_checker u_pps_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import pps_pkg::*;

    typedef struct {
        proc_req_t req;
        bit        typed;
        proc_res_t res;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    proc_req_t req;
    proc_res_t res;
    logic      res_strobe;

    proc_res_t expected_results[$];
    logic [7:0] held_arrival[MAX_PROCS];
    logic [7:0] held_burst[MAX_PROCS];
    logic [7:0] held_prio[MAX_PROCS];
    int         held_count;
    int         error_count;
    int         sets_done;
    int         results_seen;
    int         items_sent;

    preemptive_priority_schedule_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .res        (res),
        .res_strobe (res_strobe)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    function automatic void schedule_set(input proc_req_t r, ref proc_res_t outq[$]);
        logic [7:0]        remaining[MAX_PROCS];
        bit                finished[MAX_PROCS];
        logic [TICK_W-1:0] finish_tick[MAX_PROCS];
        logic [TICK_W-1:0] tick;
        logic [TICK_W-1:0] tat;
        int                left;
        int                pick;
        proc_res_t         one;
        logic [7:0]        burst;
        burst = (r.burst_time == 8'd0) ? 8'd1 : r.burst_time;
        if (held_count < MAX_PROCS)
        begin
            held_arrival[held_count] = r.arrival_time;
            held_burst[held_count] = burst;
            held_prio[held_count] = r.prio_level;
            held_count++;
        end
        if (!r.last_process)
            return;
        for (int i = 0; i < held_count; i++)
        begin
            remaining[i] = held_burst[i];
            finished[i] = 1'b0;
        end
        tick = '0;
        left = held_count;
        while (left > 0)
        begin
            pick = -1;
            for (int i = 0; i < held_count; i++)
                if (!finished[i] && held_arrival[i] <= tick &&
                    (pick < 0 || held_prio[i] > held_prio[pick]))
                    pick = i;
            tick = tick + 1'b1;
            if (pick >= 0)
            begin
                remaining[pick] = remaining[pick] - 1'b1;
                if (remaining[pick] == 8'd0)
                begin
                    finish_tick[pick] = tick;
                    finished[pick] = 1'b1;
                    left--;
                end
            end
        end
        for (int i = 0; i < held_count; i++)
        begin
            tat = finish_tick[i] - held_arrival[i];
            one.process_id = i[PID_W-1:0];
            one.completion_time = finish_tick[i];
            one.turnaround_time = tat;
            one.waiting_time = tat - held_burst[i];
            one.last_result = (i == held_count - 1);
            outq.push_back(one);
        end
        held_count = 0;
    endfunction

    task automatic send_request(input proc_req_t r, input int idle_pct, input stim_row_t row);
        proc_res_t fresh[$];
        if ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(5, 1)) @(negedge clk);
        end
        start = 1'b1;
        req = r;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        schedule_set(r, fresh);
        if (r.last_process)
            sets_done++;
        if (row.typed && fresh.size() == 1)
            expected_results.push_back(row.res);
        else
            foreach (fresh[i])
                expected_results.push_back(fresh[i]);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        proc_res_t want;
        if (rst_n && res_strobe)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result for process %0d with none expected", res.process_id);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("process_id", want.process_id, res.process_id);
                check_field("completion_time", want.completion_time, res.completion_time);
                check_field("waiting_time", want.waiting_time, res.waiting_time);
                check_field("turnaround_time", want.turnaround_time, res.turnaround_time);
                check_field("last_result", want.last_result, res.last_result);
            end
        end
    end

    function automatic stim_row_t make_row(input int a, input int b, input int p, input bit l);
        stim_row_t row;
        row.req = '{arrival_time: a[7:0], burst_time: b[7:0], prio_level: p[7:0],
                    last_process: l};
        row.typed = 1'b0;
        row.res = '0;
        return row;
    endfunction

    function automatic stim_row_t make_typed(input int a, input int b, input int p,
                                             input int ct, input int wt, input int tat);
        stim_row_t row;
        row = make_row(a, b, p, 1'b1);
        row.typed = 1'b1;
        row.res = '{process_id: '0, completion_time: ct[TICK_W-1:0],
                    waiting_time: wt[TICK_W-1:0], turnaround_time: tat[TICK_W-1:0],
                    last_result: 1'b1};
        return row;
    endfunction

    initial
    begin
        stim_row_t directed[$];
        stim_row_t row;
        proc_req_t r;
        int        idle_pct[4];
        int        set_size;
        int        phase;

        idle_pct = '{0, 60, 0, 29};
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        held_count = 0;
        error_count = 0;
        sets_done = 0;
        results_seen = 0;
        items_sent = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed.push_back(make_typed(0, 1, 0, 1, 0, 1));
        directed.push_back(make_typed(255, 255, 255, 510, 0, 255));
        directed.push_back(make_typed(0, 0, 7, 1, 0, 1));
        directed.push_back(make_row(0, 3, 5, 1'b0));
        directed.push_back(make_row(0, 2, 5, 1'b0));
        directed.push_back(make_row(1, 1, 9, 1'b1));
        directed.push_back(make_row(10, 2, 0, 1'b0));
        directed.push_back(make_row(20, 1, 255, 1'b1));
        for (int i = 0; i < MAX_PROCS; i++)
            directed.push_back(make_row(i, (i % 3) + 1, 255 - i * 17, 1'b0));
        directed.push_back(make_row(0, 4, 128, 1'b1));
        foreach (directed[i])
            send_request(directed[i].req, 0, directed[i]);
        wait (expected_results.size() == 0);

        row = make_row(0, 1, 0, 1'b0);
        phase = 0;
        while (items_sent < 345)
        begin
            if (items_sent > 25 + 80 * (phase + 1) && phase < 3)
            begin
                phase++;
                wait (expected_results.size() == 0);
                @(negedge clk);
            end
            set_size = ($urandom_range(9) == 0) ? $urandom_range(20, 17)
                                                : $urandom_range(MAX_PROCS, 1);
            for (int i = 0; i < set_size; i++)
            begin
                r.arrival_time = ($urandom_range(3) == 0) ? $urandom_range(255)
                                                          : $urandom_range(31);
                r.burst_time = ($urandom_range(7) == 0) ? $urandom_range(255)
                                                        : $urandom_range(15);
                r.prio_level = $urandom_range(255);
                r.last_process = (i == set_size - 1);
                send_request(r, idle_pct[phase], row);
            end
        end

        wait (expected_results.size() == 0);
        repeat (40) @(posedge clk);
        $display("Ran %0d requests in %0d process sets, %0d results checked,",
                 items_sent, sets_done, results_seen);
        $display("with sender idling in several phases and over-capacity sets.");
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
